FILE: rtl/core/hsle_pkg.sv
// ----------------------------------------------------------------------------
// hsle_pkg: shared types and constants of the handshake serial link engine
// Request and result layouts, link phases, register indexes, queue helpers.
// ----------------------------------------------------------------------------
package hsle_pkg;

  // Transmit byte store
  localparam int TX_DEPTH = 128;
  localparam int TX_AW    = $clog2(TX_DEPTH);

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Stream widths
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_COLLISION_WAIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MSB_FIRST      = 2'd1;
  localparam logic [3:0] COLLISION_WAIT_RST = 4'd3;

  // Bit timing
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [3:0] WAIT_MAX      = 4'd15;

  // Reported link state codes
  localparam logic [3:0] LS_IDLE      = 4'd0;
  localparam logic [3:0] LS_INCOMING  = 4'd1;
  localparam logic [3:0] LS_OUTGOING  = 4'd2;
  localparam logic [3:0] LS_COLLISION = 4'd3;
  localparam logic [3:0] LS_WAIT_ACK  = 4'd4;
  localparam logic [3:0] LS_ACK_GOT   = 4'd5;
  localparam logic [3:0] LS_ACK_SENT  = 4'd6;
  localparam logic [3:0] LS_WRITE     = 4'd7;
  localparam logic [3:0] LS_WRITE_END = 4'd8;
  localparam logic [3:0] LS_READ      = 4'd9;
  localparam logic [3:0] LS_READ_END  = 4'd10;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_QUEUE = 1'b1
  } kind_t;

  typedef enum logic [10:0] {
    PH_IDLE      = 11'b000_0000_0001,
    PH_INCOMING  = 11'b000_0000_0010,
    PH_OUTGOING  = 11'b000_0000_0100,
    PH_COLLISION = 11'b000_0000_1000,
    PH_WAIT_ACK  = 11'b000_0001_0000,
    PH_ACK_GOT   = 11'b000_0010_0000,
    PH_ACK_SENT  = 11'b000_0100_0000,
    PH_WRITE     = 11'b000_1000_0000,
    PH_WRITE_END = 11'b001_0000_0000,
    PH_READ      = 11'b010_0000_0000,
    PH_READ_END  = 11'b100_0000_0000
  } phase_t;

  // Classified request handed from front to back
  typedef struct packed {
    kind_t      kind;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       clk_pin;
    logic       request_pin;
    logic       data_pin;
  } item_t;

  typedef struct packed {
    logic [3:0] collision_wait;
    logic       msb_first;
  } cfg_t;

  typedef struct packed {
    logic       request_drive;
    logic       data_drive;
    logic       data_enable;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_message_end;
    logic       tx_dropped;
    logic [3:0] link_state;
  } result_t;

  // Circular increment of a store pointer
  function automatic logic [TX_AW-1:0] next_slot(input logic [TX_AW-1:0] p);
    logic [TX_AW-1:0] r;
    if (p == TX_AW'(TX_DEPTH - 1)) r = '0;
    else r = p + TX_AW'(1);
    return r;
  endfunction

  // Phase to reported code
  function automatic logic [3:0] phase_code(input phase_t ph);
    logic [3:0] c;
    unique case (ph)
      PH_IDLE:      c = LS_IDLE;
      PH_INCOMING:  c = LS_INCOMING;
      PH_OUTGOING:  c = LS_OUTGOING;
      PH_COLLISION: c = LS_COLLISION;
      PH_WAIT_ACK:  c = LS_WAIT_ACK;
      PH_ACK_GOT:   c = LS_ACK_GOT;
      PH_ACK_SENT:  c = LS_ACK_SENT;
      PH_WRITE:     c = LS_WRITE;
      PH_WRITE_END: c = LS_WRITE_END;
      PH_READ:      c = LS_READ;
      PH_READ_END:  c = LS_READ_END;
      default:      c = LS_IDLE;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/hsle_ram.sv
// ----------------------------------------------------------------------------
// hsle_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module hsle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/hsle_front.sv
// ----------------------------------------------------------------------------
// hsle_front: request intake of the link engine
// Takes stream requests, unpacks them into items, holds them in a short
// queue for the back end, and keeps the configuration registers.
// ----------------------------------------------------------------------------
module hsle_front (
  input  logic                              clk,
  input  logic                              rst,
  // Request stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata: [7:0] tx_byte, [8] clk_pin, [9] request_pin, [10] data_pin, rest zero
  input  logic [hsle_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic                              s_tlast,
  // s_tuser: [0] kind
  input  logic                              s_tuser,
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hsle_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hsle_pkg::CFG_DATA_W-1:0]   cfg_data,
  // To back end
  input  logic                              pop,
  output logic                              item_valid,
  output hsle_pkg::item_t                   item,
  output hsle_pkg::cfg_t                    cfg
);

  hsle_pkg::item_t                    queue [hsle_pkg::QUEUE_DEPTH];
  logic [hsle_pkg::QUEUE_AW-1:0]      wr_ptr;
  logic [hsle_pkg::QUEUE_AW-1:0]      rd_ptr;
  logic [hsle_pkg::QUEUE_CW-1:0]      count;
  hsle_pkg::item_t                    in_item;
  logic                               push;
  logic                               take;

  // Unpack the request
  always_comb begin
    in_item.kind        = hsle_pkg::kind_t'(s_tuser);
    in_item.tx_byte     = s_tdata[7:0];
    in_item.tx_last     = s_tlast;
    in_item.clk_pin     = s_tdata[8];
    in_item.request_pin = s_tdata[9];
    in_item.data_pin    = s_tdata[10];
  end

  assign s_tready   = (count != hsle_pkg::QUEUE_CW'(hsle_pkg::QUEUE_DEPTH));
  assign push       = s_tvalid && s_tready;
  assign item_valid = (count != '0);
  assign take       = pop && item_valid;
  assign item       = queue[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_item;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        if (wr_ptr == hsle_pkg::QUEUE_AW'(hsle_pkg::QUEUE_DEPTH - 1)) wr_ptr <= '0;
        else wr_ptr <= wr_ptr + hsle_pkg::QUEUE_AW'(1);
      end
      if (take) begin
        if (rd_ptr == hsle_pkg::QUEUE_AW'(hsle_pkg::QUEUE_DEPTH - 1)) rd_ptr <= '0;
        else rd_ptr <= rd_ptr + hsle_pkg::QUEUE_AW'(1);
      end
      if (push && !take) count <= count + hsle_pkg::QUEUE_CW'(1);
      else if (take && !push) count <= count - hsle_pkg::QUEUE_CW'(1);
    end
  end

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.collision_wait <= hsle_pkg::COLLISION_WAIT_RST;
      cfg.msb_first      <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        hsle_pkg::CFG_COLLISION_WAIT: cfg.collision_wait <= cfg_data;
        hsle_pkg::CFG_MSB_FIRST:      cfg.msb_first      <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/hsle_back.sv
// ----------------------------------------------------------------------------
// hsle_back: link sequencer of the engine
// Runs the link phases on each item, keeps the transmit byte store and its
// pointers, and holds each result in an output register.
// ----------------------------------------------------------------------------
module hsle_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  input  hsle_pkg::item_t                   item,
  input  hsle_pkg::cfg_t                    cfg,
  output logic                              pop,
  // Result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata: [0] request_drive, [1] data_drive, [2] data_enable, [3] rx_valid,
  //          [11:4] rx_byte, [12] tx_dropped, [16:13] link_state, rest zero
  output logic [hsle_pkg::M_TDATA_W-1:0]    m_tdata,
  // m_tlast: rx_message_end
  output logic                              m_tlast
);

  localparam int AW = hsle_pkg::TX_AW;

  hsle_pkg::phase_t   phase, phase_next;
  logic [3:0]         bit_count, bit_count_next;
  logic [3:0]         wait_count, wait_count_next;
  logic               last_clock, last_clock_next;
  logic [7:0]         rx_shift, rx_shift_next;
  logic [AW-1:0]      tx_head, tx_head_next;
  logic [AW-1:0]      tx_tail, tx_tail_next;
  logic               request_level, request_level_next;
  logic               data_level, data_level_next;
  logic               drive_enabled, drive_enabled_next;

  logic               fwd;
  logic [7:0]         fwd_data;
  logic [7:0]         rd_data;
  logic [7:0]         head_byte;
  logic [AW-1:0]      rd_addr;
  logic               we;
  logic               step;
  logic               rise, fall;
  logic [7:0]         shift_base;
  logic [7:0]         shift_new;
  logic [2:0]         bit_pos;
  hsle_pkg::result_t  res, res_next;
  logic               out_valid;

  assign step = item_valid && (!out_valid || m_tready);
  assign pop  = step;

  // Transmit byte store
  hsle_ram #(
    .WIDTH (8),
    .DEPTH (hsle_pkg::TX_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (tx_tail),
    .wdata (item.tx_byte),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Read ahead at the coming head; forward a byte written there last cycle
  assign rd_addr   = step ? tx_head_next : tx_head;
  assign head_byte = fwd ? fwd_data : rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= we && (tx_tail == rd_addr);
    end
    fwd_data <= item.tx_byte;
  end

  // Clock edge detect against the last sampled level
  assign rise = !last_clock && item.clk_pin;
  assign fall = last_clock && !item.clk_pin;

  // Received bit merged into the shift register
  assign shift_base = (bit_count == '0) ? 8'h00 : rx_shift;
  assign shift_new  = cfg.msb_first ? {shift_base[6:0], item.data_pin}
                                    : {item.data_pin, shift_base[7:1]};
  assign bit_pos    = cfg.msb_first ? ~bit_count[2:0] : bit_count[2:0];

  // Per-item transition
  always_comb begin
    phase_next         = phase;
    bit_count_next     = bit_count;
    wait_count_next    = wait_count;
    last_clock_next    = last_clock;
    rx_shift_next      = rx_shift;
    tx_head_next       = tx_head;
    tx_tail_next       = tx_tail;
    request_level_next = request_level;
    data_level_next    = data_level;
    drive_enabled_next = drive_enabled;
    we                 = 1'b0;
    res_next           = '0;

    if (item.kind == hsle_pkg::KIND_QUEUE) begin
      // Queue a transmit byte; drop it when the store is full
      if (hsle_pkg::next_slot(tx_tail) == tx_head) begin
        res_next.tx_dropped = 1'b1;
      end else begin
        we           = step;
        tx_tail_next = hsle_pkg::next_slot(tx_tail);
      end
      if (item.tx_last) begin
        phase_next         = hsle_pkg::PH_OUTGOING;
        request_level_next = 1'b1;
      end
    end else begin
      last_clock_next = item.clk_pin;
      unique case (phase)
        hsle_pkg::PH_IDLE: begin
          if (item.request_pin) phase_next = hsle_pkg::PH_INCOMING;
        end
        hsle_pkg::PH_INCOMING: begin
          request_level_next = 1'b1;
          phase_next         = hsle_pkg::PH_ACK_SENT;
        end
        hsle_pkg::PH_OUTGOING: begin
          if (item.request_pin) begin
            request_level_next = 1'b0;
            phase_next         = hsle_pkg::PH_COLLISION;
          end else begin
            request_level_next = 1'b1;
            phase_next         = hsle_pkg::PH_WAIT_ACK;
          end
        end
        hsle_pkg::PH_COLLISION: begin
          request_level_next = 1'b0;
          if (wait_count > cfg.collision_wait || wait_count == hsle_pkg::WAIT_MAX) begin
            wait_count_next = '0;
            phase_next      = hsle_pkg::PH_IDLE;
          end else begin
            wait_count_next = wait_count + 4'd1;
          end
        end
        hsle_pkg::PH_WAIT_ACK: begin
          if (fall && item.request_pin) phase_next = hsle_pkg::PH_ACK_GOT;
        end
        hsle_pkg::PH_ACK_GOT: begin
          wait_count_next    = '0;
          bit_count_next     = '0;
          drive_enabled_next = 1'b1;
          phase_next         = hsle_pkg::PH_WRITE;
        end
        hsle_pkg::PH_ACK_SENT: begin
          request_level_next = 1'b0;
          wait_count_next    = '0;
          bit_count_next     = '0;
          drive_enabled_next = 1'b0;
          phase_next         = hsle_pkg::PH_READ;
        end
        hsle_pkg::PH_WRITE: begin
          // Shift out on rising edges, one byte boundary step between bytes
          if (rise) begin
            if (bit_count == '0 && tx_head == tx_tail) begin
              phase_next = hsle_pkg::PH_WRITE_END;
            end else if (bit_count < hsle_pkg::BITS_PER_BYTE) begin
              data_level_next = head_byte[bit_pos];
              bit_count_next  = bit_count + 4'd1;
            end else begin
              bit_count_next = '0;
              tx_head_next   = hsle_pkg::next_slot(tx_head);
              if (hsle_pkg::next_slot(tx_head) == tx_tail) begin
                phase_next = hsle_pkg::PH_WRITE_END;
              end
            end
          end
        end
        hsle_pkg::PH_WRITE_END: begin
          request_level_next = 1'b0;
          phase_next         = hsle_pkg::PH_IDLE;
        end
        hsle_pkg::PH_READ: begin
          // Capture on falling edges; partner request low at a boundary ends
          if (fall) begin
            if (bit_count < hsle_pkg::BITS_PER_BYTE) begin
              rx_shift_next  = shift_new;
              bit_count_next = bit_count + 4'd1;
              if (bit_count == hsle_pkg::BITS_PER_BYTE - 4'd1) begin
                res_next.rx_valid = 1'b1;
                res_next.rx_byte  = shift_new;
              end
            end else begin
              bit_count_next = '0;
              if (!item.request_pin) phase_next = hsle_pkg::PH_READ_END;
            end
          end
        end
        hsle_pkg::PH_READ_END: begin
          res_next.rx_message_end = 1'b1;
          phase_next              = hsle_pkg::PH_IDLE;
        end
        default: begin
          phase_next = hsle_pkg::PH_IDLE;
        end
      endcase
    end

    res_next.request_drive = request_level_next;
    res_next.data_drive    = data_level_next;
    res_next.data_enable   = drive_enabled_next;
    res_next.link_state    = hsle_pkg::phase_code(phase_next);
  end

  // Link state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= hsle_pkg::PH_IDLE;
      bit_count     <= '0;
      wait_count    <= '0;
      last_clock    <= 1'b0;
      rx_shift      <= '0;
      tx_head       <= '0;
      tx_tail       <= '0;
      request_level <= 1'b0;
      data_level    <= 1'b0;
      drive_enabled <= 1'b1;
    end else if (step) begin
      phase         <= phase_next;
      bit_count     <= bit_count_next;
      wait_count    <= wait_count_next;
      last_clock    <= last_clock_next;
      rx_shift      <= rx_shift_next;
      tx_head       <= tx_head_next;
      tx_tail       <= tx_tail_next;
      request_level <= request_level_next;
      data_level    <= data_level_next;
      drive_enabled <= drive_enabled_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = res.rx_message_end;
  assign m_tdata  = {7'b0, res.link_state, res.tx_dropped, res.rx_byte, res.rx_valid,
                     res.data_enable, res.data_drive, res.request_drive};

`ifndef SYNTHESIS
  // Bit counter never passes the byte boundary step
  a_bit_count_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= hsle_pkg::BITS_PER_BYTE)
    else $error("bit counter out of range");

  // A stored byte moves the tail by one slot
  a_tail_advance: assert property (@(posedge clk) disable iff (rst)
    we |=> tx_tail == hsle_pkg::next_slot($past(tx_tail)))
    else $error("tail did not advance after store write");

  // Message end is reported together with the return to idle
  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.rx_message_end |-> res.link_state == hsle_pkg::LS_IDLE)
    else $error("message end outside idle");

  // A received byte only completes while reading
  a_rx_in_read: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.rx_valid |-> res.link_state == hsle_pkg::LS_READ)
    else $error("received byte outside read phase");
`endif

endmodule

FILE: rtl/core/handshake_serial_link_engine.sv
// ----------------------------------------------------------------------------
// handshake_serial_link_engine: clock-slave side of a four-wire byte link
// Each request is either a pin sample tick (clock, partner request and data
// levels) or one transmit byte to queue; each request yields one result.
//
// Channels: s_* carries requests, m_* carries results, cfg_* writes the
// collision wait (index 0) and bit order (index 1); cfg_ready is always high.
// Registers may be written only while no request is in flight.
//
// A taken request waits in the queue; the link sequencer then registers its
// result in the output register. Throughput: one request per cycle while
// m_tready is high; a two-entry queue sits between intake and sequencer, and
// the sequencer reads the transmit byte store ahead of its use.
// When m_tready is low the result holds in the output register, the queue
// fills, and s_tready drops once both queue entries are occupied.
//
// Reset (rst, synchronous) returns the link to idle with an empty transmit
// store, own request low and the data line driven low. The store itself is
// not cleared; no clearing pass is needed.
// ----------------------------------------------------------------------------
module handshake_serial_link_engine (
  input  logic                              clk,
  input  logic                              rst,
  // Requests
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata: [7:0] tx_byte, [8] clk_pin, [9] request_pin, [10] data_pin, rest zero
  input  logic [hsle_pkg::S_TDATA_W-1:0]    s_tdata,
  // s_tlast: tx_last
  input  logic                              s_tlast,
  // s_tuser: [0] kind
  input  logic                              s_tuser,
  // Results
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // m_tdata: [0] request_drive, [1] data_drive, [2] data_enable, [3] rx_valid,
  //          [11:4] rx_byte, [12] tx_dropped, [16:13] link_state, rest zero
  output logic [hsle_pkg::M_TDATA_W-1:0]    m_tdata,
  // m_tlast: rx_message_end
  output logic                              m_tlast,
  // Configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hsle_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hsle_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic            item_valid;
  logic            pop;
  hsle_pkg::item_t item;
  hsle_pkg::cfg_t  cfg;

  // Intake, queue and configuration
  hsle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .s_tuser    (s_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pop        (pop),
    .item_valid (item_valid),
    .item       (item),
    .cfg        (cfg)
  );

  // Link sequencer and result register
  hsle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .cfg        (cfg),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

FILE: bench/handshake_serial_link_engine_tb.sv
// ----------------------------------------------------------------------------
// handshake_serial_link_engine_tb: self-checking bench for the link engine
// Streams pin ticks and transmit bytes into the engine with random gaps on
// both sides, and predicts every result with a behavioral copy of the link
// sequencer. Covers read and write transfers, collisions, restarts, noise,
// a full transmit queue, and several register settings.
// ----------------------------------------------------------------------------
module handshake_serial_link_engine_tb;
  import hsle_pkg::*;

  localparam int RUN_LIMIT = 400000;
  localparam int ROUND_REQUESTS = 250;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // DUT connections
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  handshake_serial_link_engine dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tlast(s_tlast), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Link model state
  logic [3:0]       coll_wait;
  logic             msb_order;
  logic [3:0]       ls;
  logic [3:0]       nbits;
  logic [3:0]       waited;
  logic             prev_clk;
  logic [7:0]       rx_sr;
  logic [7:0]       tx_bytes [TX_DEPTH];
  logic [TX_AW-1:0] tx_head;
  logic [TX_AW-1:0] tx_tail;
  logic             own_req;
  logic             data_out;
  logic             drive_on;

  // Request stream and expected results
  item_t   link_requests [$];
  result_t link_results_due [$];
  item_t   out_item;
  item_t   in_item;
  result_t got;
  result_t want;
  int      pushed = 0;
  int      accepted = 0;
  int      results_seen = 0;
  int      bad_results = 0;
  int      cycles = 0;
  int      send_gap = 0;
  int      take_gap = 0;
  bit      quiet = 1'b0;
  logic    s_took = 1'b0;
  logic    m_took = 1'b0;
  logic    cfg_took = 1'b0;

  // Generator bookkeeping: clock level last sent, rough queue fill
  logic    gen_clk = 1'b0;
  int      backlog = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [TX_AW-1:0] slot_after(input logic [TX_AW-1:0] p);
    return TX_AW'((int'(p) + 1) % TX_DEPTH);
  endfunction

  function automatic void link_reset();
    coll_wait = COLLISION_WAIT_RST;
    msb_order = 1'b0;
    ls        = LS_IDLE;
    nbits     = '0;
    waited    = '0;
    prev_clk  = 1'b0;
    rx_sr     = '0;
    for (int i = 0; i < TX_DEPTH; i++) tx_bytes[i] = '0;
    tx_head   = '0;
    tx_tail   = '0;
    own_req   = 1'b0;
    data_out  = 1'b0;
    drive_on  = 1'b1;
  endfunction

  // One request through the link sequencer; returns the result it yields
  function automatic result_t link_step(input item_t it);
    result_t r;
    logic    rise;
    logic    fall;
    logic [3:0] pos;
    r = '0;
    if (it.kind == KIND_QUEUE) begin
      if (slot_after(tx_tail) == tx_head) begin
        r.tx_dropped = 1'b1;
      end else begin
        tx_bytes[tx_tail] = it.tx_byte;
        tx_tail = slot_after(tx_tail);
      end
      if (it.tx_last) begin
        ls = LS_OUTGOING;
        own_req = 1'b1;
      end
    end else begin
      rise = !prev_clk && it.clk_pin;
      fall = prev_clk && !it.clk_pin;
      prev_clk = it.clk_pin;
      case (ls)
        LS_IDLE: if (it.request_pin) ls = LS_INCOMING;
        LS_INCOMING: begin
          own_req = 1'b1;
          ls = LS_ACK_SENT;
        end
        LS_OUTGOING: begin
          if (it.request_pin) begin
            own_req = 1'b0;
            ls = LS_COLLISION;
          end else begin
            own_req = 1'b1;
            ls = LS_WAIT_ACK;
          end
        end
        LS_COLLISION: begin
          own_req = 1'b0;
          if (waited > coll_wait || waited == WAIT_MAX) begin
            waited = '0;
            ls = LS_IDLE;
          end else begin
            waited = waited + 4'd1;
          end
        end
        LS_WAIT_ACK: if (fall && it.request_pin) ls = LS_ACK_GOT;
        LS_ACK_GOT: begin
          waited = '0;
          nbits = '0;
          drive_on = 1'b1;
          ls = LS_WRITE;
        end
        LS_ACK_SENT: begin
          own_req = 1'b0;
          waited = '0;
          nbits = '0;
          drive_on = 1'b0;
          ls = LS_READ;
        end
        LS_WRITE: begin
          if (rise) begin
            if (nbits == 0 && tx_head == tx_tail) begin
              ls = LS_WRITE_END;
            end else if (nbits < BITS_PER_BYTE) begin
              pos = msb_order ? 4'd7 - nbits : nbits;
              data_out = tx_bytes[tx_head][pos[2:0]];
              nbits = nbits + 4'd1;
            end else begin
              nbits = '0;
              tx_head = slot_after(tx_head);
              if (tx_head == tx_tail) ls = LS_WRITE_END;
            end
          end
        end
        LS_WRITE_END: begin
          own_req = 1'b0;
          ls = LS_IDLE;
        end
        LS_READ: begin
          if (fall) begin
            if (nbits < BITS_PER_BYTE) begin
              if (nbits == 0) rx_sr = '0;
              rx_sr = msb_order ? {rx_sr[6:0], it.data_pin} : {it.data_pin, rx_sr[7:1]};
              nbits = nbits + 4'd1;
              if (nbits == BITS_PER_BYTE) begin
                r.rx_valid = 1'b1;
                r.rx_byte = rx_sr;
              end
            end else begin
              nbits = '0;
              if (!it.request_pin) ls = LS_READ_END;
            end
          end
        end
        LS_READ_END: begin
          r.rx_message_end = 1'b1;
          ls = LS_IDLE;
        end
        default: ls = LS_IDLE;
      endcase
    end
    r.request_drive = own_req;
    r.data_drive    = data_out;
    r.data_enable   = drive_on;
    r.link_state    = ls;
    return r;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("req %0b dat %0b en %0b rxv %0b rxb %02h end %0b drop %0b state %0d",
                     r.request_drive, r.data_drive, r.data_enable, r.rx_valid,
                     r.rx_byte, r.rx_message_end, r.tx_dropped, r.link_state);
  endfunction

  function automatic logic rnd();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic int pause_draw();
    return quiet ? 0 : $urandom_range(0, 7);
  endfunction

  // ---- stimulus building blocks ----

  task automatic queue_byte(input logic [7:0] b, input logic last);
    item_t it;
    it.kind = KIND_QUEUE;
    it.tx_byte = b;
    it.tx_last = last;
    it.clk_pin = rnd();
    it.request_pin = rnd();
    it.data_pin = rnd();
    link_requests.push_back(it);
    pushed++;
    backlog = (backlog < TX_DEPTH - 1) ? backlog + 1 : backlog;
  endtask

  task automatic pin_tick(input logic c, input logic r, input logic d);
    item_t it;
    it.kind = KIND_TICK;
    it.tx_byte = 8'($urandom);
    it.tx_last = rnd();
    it.clk_pin = c;
    it.request_pin = r;
    it.data_pin = d;
    link_requests.push_back(it);
    pushed++;
    gen_clk = c;
  endtask

  // Move the clock to a level, sometimes after a repeated sample (no edge)
  task automatic clock_to(input logic level, input logic r, input logic d);
    if ($urandom_range(0, 7) == 0) pin_tick(gen_clk, r, rnd());
    pin_tick(level, r, d);
  endtask

  task automatic clock_cycle(input logic r, input logic d_fall);
    clock_to(1'b1, r, rnd());
    clock_to(1'b0, r, d_fall);
  endtask

  // Partner answers our request: acknowledge seen on a falling edge
  task automatic ack_sequence();
    repeat ($urandom_range(0, 2)) clock_cycle(1'b0, rnd());
    if (gen_clk == 1'b0) clock_to(1'b1, 1'b0, rnd());
    clock_to(1'b0, 1'b1, rnd());
    pin_tick(1'b0, 1'b0, rnd());
  endtask

  task automatic noise(input int n);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) queue_byte(8'($urandom), rnd());
      else pin_tick(rnd(), rnd(), rnd());
    end
  endtask

  // Partner sends n bytes; a broken one stops at a random bit
  task automatic take_message(input int n, input bit broken);
    int cut;
    logic [7:0] b;
    cut = broken ? $urandom_range(0, 9 * n) : 9 * n + 1;
    repeat (3) pin_tick(gen_clk, 1'b1, rnd());
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom);
      for (int k = 0; k < 9; k++) begin
        if (cut == 0) return;
        cut--;
        if ($urandom_range(0, 15) == 0) queue_byte(8'($urandom), 1'b0);
        if (k < 8) clock_cycle(1'b1, b[k]);
        else clock_cycle(i != n - 1, rnd());
      end
    end
    pin_tick(gen_clk, 1'b0, rnd());
  endtask

  // We send n bytes; optionally collide, or restart in the middle of the write
  task automatic give_message(input int n, input bit collide, input bit restart);
    for (int i = 0; i < n; i++) queue_byte(8'($urandom), i == n - 1);
    pin_tick(gen_clk, collide, rnd());
    if (collide) begin
      repeat (18) pin_tick(rnd(), 1'b0, rnd());
      return;
    end
    ack_sequence();
    if (restart) begin
      repeat ($urandom_range(1, 9 * backlog)) clock_cycle(1'b0, rnd());
      queue_byte(8'($urandom), 1'b1);
      pin_tick(gen_clk, 1'b0, rnd());
      ack_sequence();
    end
    repeat (9 * backlog + 1) clock_cycle(1'b0, rnd());
    backlog = 0;
    pin_tick(gen_clk, 1'b0, rnd());
  endtask

  task automatic random_episode();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 3) begin
      take_message($urandom_range(1, 3), 1'b0);
    end else if (pick <= 6) begin
      give_message($urandom_range(1, 3), $urandom_range(0, 4) == 0, 1'b0);
    end else if (pick == 7) begin
      give_message($urandom_range(1, 2), 1'b0, 1'b1);
    end else begin
      if (pick == 8) noise($urandom_range(3, 12));
      else take_message($urandom_range(1, 2), 1'b1);
      // a byte marked last pulls the link back into a known sequence
      give_message(1, 1'b0, 1'b0);
    end
  endtask

  // Wait until every request is taken and every result checked
  task automatic wait_drained();
    do @(negedge clk); while (accepted != pushed || link_results_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
    if (idx == CFG_COLLISION_WAIT) coll_wait = val;
    else if (idx == CFG_MSB_FIRST) msb_order = val[0];
  endtask

  // ---- request driver ----
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_took) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (link_requests.size() > 0) begin
        out_item = link_requests.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, out_item.data_pin, out_item.request_pin, out_item.clk_pin,
                     out_item.tx_byte};
        s_tlast  <= out_item.tx_last;
        s_tuser  <= out_item.kind;
        send_gap = pause_draw();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---- result receiver stalls ----
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_took) take_gap = pause_draw();
      if (take_gap > 0) begin
        take_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---- monitor: predict on accepted requests, check accepted results ----
  always @(posedge clk) begin
    if (rst) begin
      s_took   <= 1'b0;
      m_took   <= 1'b0;
      cfg_took <= 1'b0;
    end else begin
      s_took   <= s_tvalid && s_tready;
      m_took   <= m_tvalid && m_tready;
      cfg_took <= cfg_valid && cfg_ready;
      if (s_tvalid && s_tready) begin
        in_item.kind        = kind_t'(s_tuser);
        in_item.tx_byte     = s_tdata[7:0];
        in_item.tx_last     = s_tlast;
        in_item.clk_pin     = s_tdata[8];
        in_item.request_pin = s_tdata[9];
        in_item.data_pin    = s_tdata[10];
        link_results_due.push_back(link_step(in_item));
        accepted++;
      end
      if (m_tvalid && m_tready) begin
        got.request_drive  = m_tdata[0];
        got.data_drive     = m_tdata[1];
        got.data_enable    = m_tdata[2];
        got.rx_valid       = m_tdata[3];
        got.rx_byte        = m_tdata[11:4];
        got.tx_dropped     = m_tdata[12];
        got.link_state     = m_tdata[16:13];
        got.rx_message_end = m_tlast;
        if (link_results_due.size() == 0) begin
          bad_results++;
          if (bad_results <= 10) $display("result %0d with nothing expected: %s",
                                          results_seen, show(got));
        end else begin
          want = link_results_due.pop_front();
          if (got !== want) begin
            bad_results++;
            if (bad_results <= 10) begin
              $display("result %0d mismatch", results_seen);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
        results_seen++;
      end
    end
  end

  // ---- run limit ----
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---- stimulus sequence ----
  initial begin
    link_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // byte extremes queued; the marked one starts a send that collides
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    pin_tick(1'b0, 1'b1, 1'b1);
    // collision wait runs out with the clock parked high
    repeat (6) pin_tick(1'b1, 1'b0, 1'b0);
    // incoming request, ack pulse, a couple of bits, then cut off
    repeat (3) pin_tick(1'b1, 1'b1, rnd());
    clock_cycle(1'b1, 1'b1);
    clock_cycle(1'b1, 1'b0);
    // restart mid-read: leftover bytes go out with the new one
    give_message(1, 1'b0, 1'b0);

    for (int round = 0; round < 8; round++) begin
      if (round > 0) begin
        wait_drained();
        case (round)
          1: begin
            set_reg(CFG_COLLISION_WAIT, 4'd0);
            set_reg(CFG_MSB_FIRST, 4'b0001);
          end
          2: begin
            set_reg(CFG_COLLISION_WAIT, 4'd15);
            set_reg(CFG_MSB_FIRST, 4'b1110);
          end
          3: set_reg(CFG_MSB_FIRST, 4'b1111);
          5: begin
            set_reg(CFG_COLLISION_WAIT, 4'd0);
            set_reg(CFG_MSB_FIRST, 4'b0000);
          end
          6: begin
            // unused indexes must leave the link alone
            set_reg(CFG_SPARE_A, 4'($urandom));
            set_reg(CFG_SPARE_B, 4'($urandom));
            set_reg(CFG_COLLISION_WAIT, 4'($urandom));
          end
          default: begin
            set_reg(CFG_COLLISION_WAIT, 4'($urandom));
            set_reg(CFG_MSB_FIRST, 4'($urandom));
          end
        endcase
      end
      quiet = (round == 2 || round == 5);
      begin : fill_round
        int goal;
        goal = pushed + ROUND_REQUESTS;
        while (pushed < goal) random_episode();
      end
    end

    // overfill the transmit queue: late bytes are dropped, the last still starts
    wait_drained();
    quiet = 1'b0;
    for (int i = 0; i < 131; i++) queue_byte(8'($urandom), i == 130);
    repeat (3) pin_tick(gen_clk, 1'b0, rnd());

    wait_drained();
    repeat (8) @(posedge clk);
    if (bad_results == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
